### rtl/bvf_pkg.sv
// Package for the barometric variometer filter: shared types, widths,
// register index codes, reset values and constants. No dependencies.
`default_nettype none

package bvf_pkg;

    typedef logic [31:0] alt_t;
    typedef logic [31:0] time_t;
    typedef logic [23:0] speed_t;
    typedef logic [15:0] alpha_t;
    typedef logic [2:0]  reg_index_t;
    typedef logic [31:0] reg_data_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_status_t;

    localparam int MUL_BITS = 16;
    localparam int MCAND_W  = 34;
    localparam int ACC_W    = 36;
    localparam int PROD_W   = ACC_W + MUL_BITS;

    localparam int DIV_N_W  = 47;
    localparam int DIV_D_W  = 35;
    localparam int QUO_W    = 24;

    localparam logic [ACC_W-1:0]    ROUND_BIAS = ACC_W'(32768);
    localparam logic [MUL_BITS-1:0] MM_NUM     = MUL_BITS'(9525);

    localparam speed_t SPEED_MAX = 24'h7F_FFFF;
    localparam speed_t SPEED_MIN = 24'h80_0000;
    localparam alt_t   ALT_MAX   = 32'h7FFF_FFFF;
    localparam alt_t   ALT_MIN   = 32'h8000_0000;

    localparam reg_index_t REG_ALT_ALPHA  = 3'd0;
    localparam reg_index_t REG_RATE_ALPHA = 3'd1;
    localparam reg_index_t REG_WARMUP_MS  = 3'd2;
    localparam reg_index_t REG_ZERO_SAVED = 3'd3;
    localparam reg_index_t REG_SAVED_ZERO = 3'd4;
    localparam reg_index_t REG_GPS_MODE   = 3'd5;

    localparam alpha_t ALT_ALPHA_RST  = 16'd6554;
    localparam alpha_t RATE_ALPHA_RST = 16'd19661;
    localparam alpha_t WARMUP_MS_RST  = 16'd3000;

    localparam logic OP_SAMPLE  = 1'b0;
    localparam logic OP_RESTART = 1'b1;

endpackage

`default_nettype wire

### rtl/bvf_if.sv
// Handshake channels of the variometer filter: sample input and result output.
// Depends on bvf_pkg for payload types.
`default_nettype none

interface bvf_in_if;
    logic           valid;
    logic           ready;
    logic           op;
    bvf_pkg::alt_t  altitude_sample;
    bvf_pkg::time_t time_ms;

    modport source (output valid, op, altitude_sample, time_ms, input ready);
    modport sink (input valid, op, altitude_sample, time_ms, output ready);
endinterface

interface bvf_out_if;
    logic            valid;
    logic            ready;
    bvf_pkg::alt_t   relative_altitude;
    logic            altitude_valid;
    bvf_pkg::speed_t vertical_speed;
    logic            warmed_up;
    bvf_pkg::alt_t   smoothed_altitude;

    modport source (output valid, relative_altitude, altitude_valid, vertical_speed,
                    warmed_up, smoothed_altitude, input ready);
    modport sink (input valid, relative_altitude, altitude_valid, vertical_speed,
                  warmed_up, smoothed_altitude, output ready);
endinterface

`default_nettype wire

### rtl/baro_vario_filter.sv
// Variometer filter top level: configuration registers, filter state,
// sequencer and output register. Depends on bvf_pkg, bvf_if, bvf_ser_mul, bvf_ser_div.
//
// Each transaction on samples yields one transaction on results. A restart or
// the priming sample needs no arithmetic; a sample that only smooths runs one
// product; a sample that forms a climb rate runs three products and a division.
// The arithmetic runs on the shared bit-serial multiplier (up to three products)
// and the restoring divider (47-bit dividend). samples.ready
// is high whenever the sequencer is idle, even while a result waits on results.
`default_nettype none

module baro_vario_filter (
    input  wire                       clk,
    input  wire                       rst_n,
    bvf_in_if.sink                    samples,
    bvf_out_if.source                 results,
    input  wire                       wr_en,
    input  wire  bvf_pkg::reg_index_t wr_index,
    input  wire  bvf_pkg::reg_data_t  wr_data
);
    import bvf_pkg::*;

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_DECIDE    = 3'd1;
    localparam logic [2:0] S_ALT_MUL   = 3'd2;
    localparam logic [2:0] S_MAG_START = 3'd3;
    localparam logic [2:0] S_MAG_MUL   = 3'd4;
    localparam logic [2:0] S_DIV       = 3'd5;
    localparam logic [2:0] S_RATE_MUL  = 3'd6;
    localparam logic [2:0] S_FINISH    = 3'd7;

    // configuration
    alpha_t alt_alpha_reg;
    alpha_t rate_alpha_reg;
    alpha_t warmup_ms_reg;
    logic   zero_saved_reg;
    alt_t   saved_zero_reg;
    logic   gps_mode_reg;

    // filter state
    alt_t   smooth_reg;
    alt_t   prev_reg;
    alt_t   zero_reg;
    time_t  last_reg;
    time_t  wstart_reg;
    logic   primed_reg;
    logic   warm_reg;
    speed_t speed_reg;

    // sequencer and latched transaction
    logic [2:0] fsm_reg;
    logic       op_reg;
    alt_t       sample_reg;
    time_t      now_reg;
    logic       neg_reg;

    // output register
    logic   out_valid_reg;
    alt_t   rel_reg;
    logic   aval_reg;
    speed_t vs_reg;
    logic   wu_reg;
    alt_t   sm_reg;

    // units
    logic                mul_start;
    logic [MCAND_W-1:0]  mul_mcand;
    logic [MUL_BITS-1:0] mul_mplier;
    logic [ACC_W-1:0]    mul_bias;
    logic [PROD_W-1:0]   mul_prod;
    unit_status_t        mul_st;
    logic                div_start;
    logic [QUO_W-1:0]    div_quo;
    logic                div_ovf;
    unit_status_t        div_st;

    // datapath
    time_t       dt;
    time_t       elapsed;
    logic        warm_hit;
    logic [32:0] alt_diff;
    alt_t        smooth_new;
    logic [32:0] d_wide;
    alt_t        d_sat;
    alt_t        mag;
    speed_t      m_meas;
    logic [24:0] rate_diff;
    speed_t      speed_new;
    alt_t        zero_sel;
    logic [32:0] rel_wide;
    alt_t        rel_sat;
    logic        valid_now;
    logic        accept;
    logic        out_free;

    assign accept   = samples.valid && samples.ready;
    assign out_free = !out_valid_reg || results.ready;

    assign dt       = now_reg - last_reg;
    assign elapsed  = now_reg - wstart_reg;
    assign warm_hit = !warm_reg && (elapsed >= {16'd0, warmup_ms_reg});

    assign alt_diff   = {sample_reg[31], sample_reg} - {smooth_reg[31], smooth_reg};
    assign smooth_new = smooth_reg + mul_prod[MUL_BITS +: 32];

    assign d_wide = {smooth_reg[31], smooth_reg} - {prev_reg[31], prev_reg};
    always_comb
    begin
        if (d_wide[32] != d_wide[31])
            d_sat = d_wide[32] ? ALT_MIN : ALT_MAX;
        else
            d_sat = d_wide[31:0];
    end
    assign mag = d_sat[31] ? (32'd0 - d_sat) : d_sat;

    always_comb
    begin
        if (neg_reg)
        begin
            if (div_ovf || (div_quo[QUO_W-1] && (div_quo[QUO_W-2:0] != '0)))
                m_meas = SPEED_MIN;
            else
                m_meas = 24'd0 - div_quo;
        end
        else
        begin
            if (div_ovf || div_quo[QUO_W-1])
                m_meas = SPEED_MAX;
            else
                m_meas = div_quo;
        end
    end

    assign rate_diff = {m_meas[23], m_meas} - {speed_reg[23], speed_reg};
    assign speed_new = speed_reg + mul_prod[MUL_BITS +: 24];

    assign zero_sel  = zero_saved_reg ? saved_zero_reg : zero_reg;
    assign rel_wide  = {smooth_reg[31], smooth_reg} - {zero_sel[31], zero_sel};
    assign valid_now = primed_reg && !gps_mode_reg;
    always_comb
    begin
        if (!valid_now)
            rel_sat = '0;
        else if (rel_wide[32] != rel_wide[31])
            rel_sat = rel_wide[32] ? ALT_MIN : ALT_MAX;
        else
            rel_sat = rel_wide[31:0];
    end

    assign mul_start = ((fsm_reg == S_DECIDE) && (op_reg == OP_SAMPLE) && primed_reg)
                     || (fsm_reg == S_MAG_START)
                     || ((fsm_reg == S_DIV) && div_st.done);
    assign div_start = (fsm_reg == S_MAG_MUL) && mul_st.done;

    always_comb
    begin
        unique case (fsm_reg)
            S_DECIDE:
            begin
                mul_mcand  = {alt_diff[32], alt_diff};
                mul_mplier = alt_alpha_reg;
                mul_bias   = ROUND_BIAS;
            end
            S_MAG_START:
            begin
                mul_mcand  = {2'b00, mag};
                mul_mplier = MM_NUM;
                mul_bias   = {2'b00, dt, 2'b00};
            end
            default:
            begin
                mul_mcand  = {{(MCAND_W-25){rate_diff[24]}}, rate_diff};
                mul_mplier = rate_alpha_reg;
                mul_bias   = ROUND_BIAS;
            end
        endcase
    end

    bvf_ser_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .mcand   (mul_mcand),
        .mplier  (mul_mplier),
        .bias    (mul_bias),
        .product (mul_prod),
        .status  (mul_st)
    );

    bvf_ser_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .numer    (mul_prod[DIV_N_W-1:0]),
        .denom    ({dt, 3'b000}),
        .quotient (div_quo),
        .overflow (div_ovf),
        .status   (div_st)
    );

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alt_alpha_reg  <= ALT_ALPHA_RST;
            rate_alpha_reg <= RATE_ALPHA_RST;
            warmup_ms_reg  <= WARMUP_MS_RST;
            zero_saved_reg <= 1'b0;
            saved_zero_reg <= '0;
            gps_mode_reg   <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_ALT_ALPHA:  alt_alpha_reg  <= wr_data[15:0];
                REG_RATE_ALPHA: rate_alpha_reg <= wr_data[15:0];
                REG_WARMUP_MS:  warmup_ms_reg  <= wr_data[15:0];
                REG_ZERO_SAVED: zero_saved_reg <= wr_data[0];
                REG_SAVED_ZERO: saved_zero_reg <= wr_data;
                REG_GPS_MODE:   gps_mode_reg   <= wr_data[0];
                default:        ;
            endcase
        end
    end

    // sequencer and filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg    <= S_IDLE;
            smooth_reg <= '0;
            prev_reg   <= '0;
            zero_reg   <= '0;
            last_reg   <= '0;
            wstart_reg <= '0;
            primed_reg <= 1'b0;
            warm_reg   <= 1'b0;
            speed_reg  <= '0;
            neg_reg    <= 1'b0;
        end
        else
        begin
            unique case (fsm_reg)
                S_IDLE:
                begin
                    if (accept)
                        fsm_reg <= S_DECIDE;
                end
                S_DECIDE:
                begin
                    if (op_reg == OP_RESTART)
                    begin
                        primed_reg <= 1'b0;
                        warm_reg   <= 1'b0;
                        speed_reg  <= '0;
                        wstart_reg <= now_reg;
                        fsm_reg    <= S_FINISH;
                    end
                    else if (!primed_reg)
                    begin
                        smooth_reg <= sample_reg;
                        prev_reg   <= sample_reg;
                        if (!zero_saved_reg)
                            zero_reg <= sample_reg;
                        last_reg   <= now_reg;
                        primed_reg <= 1'b1;
                        fsm_reg    <= S_FINISH;
                    end
                    else
                        fsm_reg <= S_ALT_MUL;
                end
                S_ALT_MUL:
                begin
                    if (mul_st.done)
                    begin
                        smooth_reg <= smooth_new;
                        if (warm_hit)
                        begin
                            if (!zero_saved_reg)
                                zero_reg <= smooth_new;
                            prev_reg  <= smooth_new;
                            speed_reg <= '0;
                            last_reg  <= now_reg;
                            warm_reg  <= 1'b1;
                            fsm_reg   <= S_FINISH;
                        end
                        else if (warm_reg && (dt != '0))
                            fsm_reg <= S_MAG_START;
                        else
                            fsm_reg <= S_FINISH;
                    end
                end
                S_MAG_START:
                begin
                    neg_reg <= d_sat[31];
                    fsm_reg <= S_MAG_MUL;
                end
                S_MAG_MUL:
                begin
                    if (mul_st.done)
                        fsm_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (div_st.done)
                        fsm_reg <= S_RATE_MUL;
                end
                S_RATE_MUL:
                begin
                    if (mul_st.done)
                    begin
                        speed_reg <= speed_new;
                        prev_reg  <= smooth_reg;
                        last_reg  <= now_reg;
                        fsm_reg   <= S_FINISH;
                    end
                end
                S_FINISH:
                begin
                    if (out_free)
                        fsm_reg <= S_IDLE;
                end
                default:
                    fsm_reg <= S_IDLE;
            endcase
        end
    end

    // latch the accepted transaction
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= samples.op;
            sample_reg <= samples.altitude_sample;
            now_reg    <= samples.time_ms;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if ((fsm_reg == S_FINISH) && out_free)
            out_valid_reg <= 1'b1;
        else if (results.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if ((fsm_reg == S_FINISH) && out_free)
        begin
            rel_reg  <= rel_sat;
            aval_reg <= valid_now;
            vs_reg   <= speed_reg;
            wu_reg   <= warm_reg;
            sm_reg   <= smooth_reg;
        end
    end

    assign samples.ready             = (fsm_reg == S_IDLE);
    assign results.valid             = out_valid_reg;
    assign results.relative_altitude = rel_reg;
    assign results.altitude_valid    = aval_reg;
    assign results.vertical_speed    = vs_reg;
    assign results.warmed_up         = wu_reg;
    assign results.smoothed_altitude = sm_reg;

    a_mul_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        mul_start |-> !mul_st.busy)
        else $error("multiplier started while busy");

    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_st.busy)
        else $error("divider started while busy");

    a_warm_primed: assert property (@(posedge clk) disable iff (!rst_n)
        warm_reg |-> primed_reg)
        else $error("warmup done without priming");

    a_accept_decide: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (fsm_reg == S_DECIDE))
        else $error("accepted transaction not taken up");

    a_mul_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mul_st.done |-> (fsm_reg == S_ALT_MUL || fsm_reg == S_MAG_MUL
                         || fsm_reg == S_RATE_MUL))
        else $error("product finished with no consumer");

endmodule

`default_nettype wire

### rtl/bvf_ser_mul.sv
// Bit-serial shift-add multiplier: signed multiplicand, unsigned multiplier,
// one multiplier bit per cycle, with a preloaded bias. Depends on bvf_pkg.
`default_nettype none

module bvf_ser_mul (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            start,
    input  wire  [bvf_pkg::MCAND_W-1:0]    mcand,
    input  wire  [bvf_pkg::MUL_BITS-1:0]   mplier,
    input  wire  [bvf_pkg::ACC_W-1:0]      bias,
    output logic [bvf_pkg::PROD_W-1:0]     product,
    output bvf_pkg::unit_status_t          status
);
    import bvf_pkg::*;

    localparam int CNT_W = $clog2(MUL_BITS);

    logic [ACC_W-1:0]    hi_reg, hi_next;
    logic [MUL_BITS-1:0] lo_reg, lo_next;
    logic [MUL_BITS-1:0] q_reg, q_next;
    logic [MCAND_W-1:0]  m_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                busy_reg;
    logic                done_reg;
    logic [ACC_W-1:0]    addend;
    logic [ACC_W-1:0]    sum;
    logic                last;

    assign addend = q_reg[0] ? {{(ACC_W-MCAND_W){m_reg[MCAND_W-1]}}, m_reg} : '0;
    assign sum    = hi_reg + addend;
    assign last   = (cnt_reg == CNT_W'(MUL_BITS - 1));

    always_comb
    begin
        hi_next = {sum[ACC_W-1], sum[ACC_W-1:1]};
        lo_next = {sum[0], lo_reg[MUL_BITS-1:1]};
        q_next  = {1'b0, q_reg[MUL_BITS-1:1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (last)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            hi_reg <= bias;
            lo_reg <= '0;
            q_reg  <= mplier;
            m_reg  <= mcand;
        end
        else if (busy_reg)
        begin
            hi_reg <= hi_next;
            lo_reg <= lo_next;
            q_reg  <= q_next;
        end
    end

    assign product     = {hi_reg, lo_reg};
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

`default_nettype wire

### rtl/bvf_ser_div.sv
// Restoring divider, one quotient bit per cycle, with sticky overflow above
// the kept quotient bits. Depends on bvf_pkg.
`default_nettype none

module bvf_ser_div (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            start,
    input  wire  [bvf_pkg::DIV_N_W-1:0]    numer,
    input  wire  [bvf_pkg::DIV_D_W-1:0]    denom,
    output logic [bvf_pkg::QUO_W-1:0]      quotient,
    output logic                           overflow,
    output bvf_pkg::unit_status_t          status
);
    import bvf_pkg::*;

    localparam int CNT_W = $clog2(DIV_N_W);

    logic [DIV_N_W-1:0] n_reg;
    logic [DIV_D_W-1:0] d_reg;
    logic [DIV_D_W-1:0] rem_reg, rem_next;
    logic [QUO_W-1:0]   q_reg;
    logic               ovf_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [DIV_D_W:0]   trial;
    logic [DIV_D_W:0]   diff;
    logic               fits;
    logic               last;

    assign trial    = {rem_reg, n_reg[DIV_N_W-1]};
    assign diff     = trial - {1'b0, d_reg};
    assign fits     = (trial >= {1'b0, d_reg});
    assign rem_next = fits ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
    assign last     = (cnt_reg == CNT_W'(DIV_N_W - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (last)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg   <= numer;
            d_reg   <= denom;
            rem_reg <= '0;
            q_reg   <= '0;
            ovf_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            n_reg   <= {n_reg[DIV_N_W-2:0], 1'b0};
            rem_reg <= rem_next;
            q_reg   <= {q_reg[QUO_W-2:0], fits};
            ovf_reg <= ovf_reg | q_reg[QUO_W-1];
        end
    end

    assign quotient    = q_reg;
    assign overflow    = ovf_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

`default_nettype wire
